// ----- hdl/afk_pkg.sv -----
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and fixed-point helpers for the 7-joint arm
// forward kinematics block.
// ----------------------------------------------------------------------------
package afk_pkg;

  localparam int unsigned NumJoints = 7;
  localparam int unsigned AngW      = 16;
  localparam int unsigned TrigW     = 16;
  localparam int unsigned LenW      = 17;
  localparam int unsigned RotW      = 16;
  localparam int unsigned PosW      = 20;
  localparam int unsigned WideW     = 24;
  localparam int unsigned InDataW   = 112;
  localparam int unsigned OutDataW  = 208;
  localparam int unsigned CfgAddrW  = 4;

  localparam logic [CfgAddrW-1:0] AddrBase  = 4'h0;
  localparam logic [CfgAddrW-1:0] AddrUpper = 4'h4;
  localparam logic [CfgAddrW-1:0] AddrFore  = 4'h8;
  localparam logic [CfgAddrW-1:0] AddrWrist = 4'hC;

  localparam logic [LenW-1:0] BaseRst  = 17'd23593;
  localparam logic [LenW-1:0] UpperRst = 17'd27525;
  localparam logic [LenW-1:0] ForeRst  = 17'd26214;
  localparam logic [LenW-1:0] WristRst = 17'd23986;

  typedef logic signed [TrigW-1:0] trig_t;
  typedef logic signed [WideW-1:0] wide_t;

  typedef struct packed {
    trig_t s;
    trig_t c;
  } sc_t;

  typedef struct packed {
    logic [LenW-1:0] d1;
    logic [LenW-1:0] d3;
    logic [LenW-1:0] d5;
    logic [LenW-1:0] d7;
  } len_t;

  // a*b/2^14, rounded to nearest, ties toward +inf (floor of p+2^13)
  function automatic wide_t mq(input wide_t a, input wide_t b);
    logic signed [2*WideW-1:0] p;
    p = a * b + (2*WideW)'(signed'(8192));
    return wide_t'(p >>> 14);
  endfunction

  function automatic trig_t clamp_rot(input wide_t v);
    wide_t r;
    r = v;
    if (v > wide_t'(16384)) r = wide_t'(16384);
    if (v < -wide_t'(16384)) r = -wide_t'(16384);
    return trig_t'(r);
  endfunction

  function automatic logic signed [PosW-1:0] clamp_pos(input logic signed [WideW+4:0] v);
    logic signed [WideW+4:0] r;
    r = v;
    if (v > (WideW+5)'(signed'(524287))) r = (WideW+5)'(signed'(524287));
    if (v < -(WideW+5)'(signed'(524288))) r = -(WideW+5)'(signed'(524288));
    return r[PosW-1:0];
  endfunction

endpackage

// ----- hdl/afk_sincos.sv -----
// ----------------------------------------------------------------------------
// afk_sincos
// One sine/cosine lane: polynomial sine on a binary angle, four registered
// stages.
// ----------------------------------------------------------------------------
module afk_sincos (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [15:0]          angle_i,
  output afk_pkg::sc_t         sc_o
);
  import afk_pkg::*;

  logic [1:0]  qs_q, qc_q, qs2_q, qc2_q, qs3_q, qc3_q;
  logic [16:0] us_q, uc_q, us2_q, uc2_q, us3_q, uc3_q;
  logic [16:0] u2s_q, u2c_q;
  logic [16:0] t2s_q, t2c_q;
  logic [15:0] ac;
  logic [13:0] zs, zc;
  logic [16:0] us_d, uc_d;

  function automatic logic [16:0] fold(input logic [1:0] q, input logic [13:0] z);
    logic [14:0] zz;
    zz = q[0] ? (15'd16384 - {1'b0, z}) : {1'b0, z};
    return {zz, 2'b00};
  endfunction

  function automatic logic [16:0] sq(input logic [16:0] u);
    logic [33:0] p;
    p = u * u;
    return p[32:16];
  endfunction

  function automatic logic [16:0] poly(input logic [16:0] u2);
    logic [33:0] p1;
    logic [16:0] t1;
    logic [35:0] p2;
    p1 = u2 * 17'd4640;
    t1 = p1[32:16];
    p2 = u2 * (18'd42047 - {1'b0, t1});
    return p2[32:16];
  endfunction

  function automatic trig_t finish(input logic [1:0] q, input logic [16:0] u,
                                   input logic [16:0] t2);
    logic [35:0] p3;
    logic [17:0] m;
    logic [16:0] mag;
    p3 = u * (18'd102944 - {1'b0, t2});
    m = p3[33:16];
    mag = 17'((m + 18'd2) >> 2);
    if (mag > 17'd16384) mag = 17'd16384;
    return q[1] ? -trig_t'(mag) : trig_t'(mag);
  endfunction

  assign ac   = angle_i + 16'd16384;
  assign zs   = angle_i[13:0];
  assign zc   = ac[13:0];
  assign us_d = fold(angle_i[15:14], zs);
  assign uc_d = fold(ac[15:14], zc);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qs_q  <= angle_i[15:14];
      qc_q  <= ac[15:14];
      us_q  <= us_d;
      uc_q  <= uc_d;
      qs2_q <= qs_q;
      qc2_q <= qc_q;
      us2_q <= us_q;
      uc2_q <= uc_q;
      u2s_q <= sq(us_q);
      u2c_q <= sq(uc_q);
      qs3_q <= qs2_q;
      qc3_q <= qc2_q;
      us3_q <= us2_q;
      uc3_q <= uc2_q;
      t2s_q <= poly(u2s_q);
      t2c_q <= poly(u2c_q);
      sc_o.s <= finish(qs3_q, us3_q, t2s_q);
      sc_o.c <= finish(qc3_q, uc3_q, t2c_q);
    end
  end

endmodule

// ----- hdl/afk_merge.sv -----
// ----------------------------------------------------------------------------
// afk_merge
// Merge the seven sine/cosine lanes into the pose: a pipeline with one
// product level per stage.
// ----------------------------------------------------------------------------
module afk_merge (
  input  logic         clk_i,
  input  logic         en_i,
  input  afk_pkg::sc_t sc_i [7],
  input  afk_pkg::len_t len_i,
  output logic [15:0]  rot_o [9],
  output logic [19:0]  pos_o [3]
);
  import afk_pkg::*;

  wide_t s [7], c [7];
  wide_t s1 [7], c1 [7], s2 [7], c2 [7], s3 [7], c3 [7], s4 [7], c4 [7];
  wide_t s5 [7], c5 [7];
  // stage A: pair products
  wide_t a_c0c1, a_c0s1, a_c1c2, a_c1s0, a_s0s1, a_c0c3, a_c3s0, a_c2c3, a_c2s1,
         a_s1s2, a_c4s1, a_s0s2, a_c0s2, a_c2s0, a_c0c2, a_c1s3, a_c1c3;
  // stage B
  wide_t b_p0, b_q0, b_p1, b_q1, b_g, b_h, b_t0a, b_t0b, b_t1a, b_t1b, b_u2b, b_x2b;
  // stage C
  wide_t c_u0, c_v0, c_u1, c_v1, c_u2, c_x2, c_q0, c_q1, c_h;
  // stage D
  wide_t d_w0, d_x0, d_w1, d_x1, d_y2, d_r8, d_v0, d_v1, d_x2, d_h;
  // stage E
  wide_t e_y0, e_r2, e_y1, e_r5, e_x0, e_x1, e_r6, e_r7, e_r8, e_v0, e_v1, e_h;
  // stage F
  wide_t f_r [9];
  wide_t f_px, f_py, f_pz;
  logic [LenW-1:0] e_d1;
  wide_t b_d3c0s1, b_d3s0s1, b_d3c1, c_d3a, c_d3b, c_d3c, d_d3a, d_d3b, d_d3c,
         e_d3a, e_d3b, e_d3c;

  for (genvar j = 0; j < 7; j++) begin : g_ext
    assign s[j] = wide_t'(sc_i[j].s);
    assign c[j] = wide_t'(sc_i[j].c);
  end

  wide_t d3w, d5w, d7w;
  assign d3w = wide_t'(len_i.d3);
  assign d5w = wide_t'(len_i.d5);
  assign d7w = wide_t'(len_i.d7);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1 <= s; c1 <= c;
      a_c0c1 <= mq(c[0], c[1]); a_c0s1 <= mq(c[0], s[1]); a_c1c2 <= mq(c[1], c[2]);
      a_c1s0 <= mq(c[1], s[0]); a_s0s1 <= mq(s[0], s[1]); a_c0c3 <= mq(c[0], c[3]);
      a_c3s0 <= mq(c[3], s[0]); a_c2c3 <= mq(c[2], c[3]); a_c2s1 <= mq(c[2], s[1]);
      a_s1s2 <= mq(s[1], s[2]); a_c4s1 <= mq(c[4], s[1]); a_s0s2 <= mq(s[0], s[2]);
      a_c0s2 <= mq(c[0], s[2]); a_c2s0 <= mq(c[2], s[0]); a_c0c2 <= mq(c[0], c[2]);
      a_c1s3 <= mq(c[1], s[3]); a_c1c3 <= mq(c[1], c[3]);

      s2 <= s1; c2 <= c1;
      b_p0 <= a_s0s2 - mq(a_c0c1, c1[2]);
      b_q0 <= a_c2s0 + mq(a_c0c1, s1[2]);
      b_p1 <= a_c0s2 + mq(a_c1c2, s1[0]);
      b_q1 <= a_c0c2 - mq(a_c1s0, s1[2]);
      b_g  <= a_c1s3 - mq(a_c2c3, s1[1]);
      b_h  <= a_c1c3 + mq(a_c2s1, s1[3]);
      b_t0a <= mq(a_c0s1, s1[3]);
      b_t0b <= mq(a_c0c3, s1[1]);
      b_t1a <= mq(a_s0s1, s1[3]);
      b_t1b <= mq(a_c3s0, s1[1]);
      b_u2b <= mq(a_s1s2, s1[4]);
      b_x2b <= mq(a_c4s1, s1[2]);
      b_d3c0s1 <= mq(d3w, a_c0s1);
      b_d3s0s1 <= mq(d3w, a_s0s1);
      b_d3c1   <= mq(d3w, c1[1]);

      s3 <= s2; c3 <= c2;
      c_u0 <= mq(c2[3], b_p0) - b_t0a;
      c_v0 <= mq(s2[3], b_p0) + b_t0b;
      c_u1 <= mq(c2[3], b_p1) + b_t1a;
      c_v1 <= mq(s2[3], b_p1) - b_t1b;
      c_u2 <= mq(c2[4], b_g) + b_u2b;
      c_x2 <= mq(s2[4], b_g) - b_x2b;
      c_q0 <= b_q0; c_q1 <= b_q1; c_h <= b_h;
      c_d3a <= b_d3c0s1; c_d3b <= b_d3s0s1; c_d3c <= b_d3c1;

      s4 <= s3; c4 <= c3;
      d_w0 <= mq(c3[4], c_u0) + mq(s3[4], c_q0);
      d_x0 <= mq(s3[4], c_u0) - mq(c3[4], c_q0);
      d_w1 <= mq(c3[4], c_u1) + mq(s3[4], c_q1);
      d_x1 <= mq(s3[4], c_u1) - mq(c3[4], c_q1);
      d_y2 <= mq(c3[5], c_u2) - mq(s3[5], c_h);
      d_r8 <= mq(s3[5], c_u2) + mq(c3[5], c_h);
      d_v0 <= c_v0; d_v1 <= c_v1; d_x2 <= c_x2; d_h <= c_h;
      d_d3a <= c_d3a; d_d3b <= c_d3b; d_d3c <= c_d3c;

      s5 <= s4; c5 <= c4;
      e_y0 <= mq(s4[5], d_v0) + mq(c4[5], d_w0);
      e_r2 <= mq(c4[5], d_v0) - mq(s4[5], d_w0);
      e_y1 <= mq(s4[5], d_v1) + mq(c4[5], d_w1);
      e_r5 <= mq(s4[5], d_w1) - mq(c4[5], d_v1);
      e_x0 <= d_x0; e_x1 <= d_x1;
      e_r6 <= mq(c4[6], d_y2) - mq(s4[6], d_x2);
      e_r7 <= -mq(c4[6], d_x2) - mq(s4[6], d_y2);
      e_r8 <= d_r8;
      e_v0 <= mq(d5w, d_v0); e_v1 <= mq(d5w, d_v1); e_h <= mq(d5w, d_h);
      e_d1 <= len_i.d1;
      e_d3a <= d_d3a; e_d3b <= d_d3b; e_d3c <= d_d3c;

      f_r[0] <= mq(s5[6], e_x0) - mq(c5[6], e_y0);
      f_r[1] <= mq(c5[6], e_x0) + mq(s5[6], e_y0);
      f_r[2] <= e_r2;
      f_r[3] <= mq(c5[6], e_y1) - mq(s5[6], e_x1);
      f_r[4] <= -mq(c5[6], e_x1) - mq(s5[6], e_y1);
      f_r[5] <= e_r5;
      f_r[6] <= e_r6; f_r[7] <= e_r7; f_r[8] <= e_r8;
      f_px <= mq(d7w, e_r2) + e_v0 + e_d3a;
      f_py <= e_d3b - e_v1 + mq(d7w, e_r5);
      f_pz <= wide_t'(e_d1) + e_h + mq(d7w, e_r8) + e_d3c;

      for (int k = 0; k < 9; k++) rot_o[k] <= clamp_rot(f_r[k]);
      pos_o[0] <= clamp_pos((WideW+5)'(f_px));
      pos_o[1] <= clamp_pos((WideW+5)'(f_py));
      pos_o[2] <= clamp_pos((WideW+5)'(f_pz));
    end
  end

endmodule

// ----- hdl/arm_forward_kinematics_7dof.sv -----
// ----------------------------------------------------------------------------
// arm_forward_kinematics_7dof
// Closed-form pose of a 7-joint arm from seven binary joint angles.
//
// s_axis: tdata holds angle_j1..angle_j7 (16 bits each, j1 lowest).
// m_axis: tdata holds rot_r0c0..rot_r2c2 (16 bits each) then pos_x, pos_y,
//   pos_z (20 bits each), rot_r0c0 lowest.
// APB: link lengths at 0x0 (base), 0x4 (upper arm), 0x8 (forearm),
//   0xC (wrist plus tool); write only while idle.
// Throughput: one transaction per cycle while the receiver does not stall.
//   From input acceptance to output valid, data passes four sine lane
//   stages, six merge stages and the output register.
// The whole pipeline advances as one; when the receiver stalls with valid
//   output held, the pipeline holds and s_axis_tready drops.
// Reset empties the pipeline and loads the default link lengths.
// ----------------------------------------------------------------------------
module arm_forward_kinematics_7dof (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [afk_pkg::InDataW-1:0]   s_axis_tdata,  // angle_j1..angle_j7
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [afk_pkg::OutDataW-1:0]  m_axis_tdata,  // rot_r0c0..rot_r2c2,pos_x,y,z
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afk_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import afk_pkg::*;

  localparam int unsigned Lat = 11;

  len_t len_q;
  logic [Lat-1:0] vld_q;
  logic en;
  sc_t sc [7];
  logic [15:0] rot [9];
  logic [19:0] pos [3];
  logic wr;

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      len_q <= '{d1: BaseRst, d3: UpperRst, d5: ForeRst, d7: WristRst};
    end else begin
      if (en) vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
      if (wr) begin
        unique case (paddr)
          AddrBase:  len_q.d1 <= pwdata[LenW-1:0];
          AddrUpper: len_q.d3 <= pwdata[LenW-1:0];
          AddrFore:  len_q.d5 <= pwdata[LenW-1:0];
          AddrWrist: len_q.d7 <= pwdata[LenW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr)
      AddrBase:  prdata = 32'(len_q.d1);
      AddrUpper: prdata = 32'(len_q.d3);
      AddrFore:  prdata = 32'(len_q.d5);
      AddrWrist: prdata = 32'(len_q.d7);
      default:   prdata = '0;
    endcase
  end

  for (genvar j = 0; j < 7; j++) begin : g_lane
    afk_sincos u_sc (
      .clk_i   (clk_i),
      .en_i    (en),
      .angle_i (s_axis_tdata[16*j +: 16]),
      .sc_o    (sc[j])
    );
  end

  afk_merge u_merge (
    .clk_i (clk_i),
    .en_i  (en),
    .sc_i  (sc),
    .len_i (len_q),
    .rot_o (rot),
    .pos_o (pos)
  );

  for (genvar k = 0; k < 9; k++) begin : g_rot
    assign m_axis_tdata[16*k +: 16] = rot[k];
  end
  for (genvar k = 0; k < 3; k++) begin : g_pos
    assign m_axis_tdata[144 + 20*k +: 20] = pos[k];
  end
  assign m_axis_tdata[OutDataW-1:204] = '0;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("stalled without pending output");
  a_vld_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && !s_axis_tvalid |=> !vld_q[0])
    else $error("phantom item");

endmodule
